// File: sv/evt_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants, codes, payload types and the marker table of the turn taker.
package evt_pkg;

    localparam int FRAME_SAMPLES  = 320;
    localparam int FRAME_MS       = 20;
    localparam int PREROLL_FRAMES = 16;
    localparam int ONSET_FRAMES   = 3;

    localparam int ACT_W    = 2;
    localparam int SAMPLE_W = 16;
    localparam int BYTE_W   = 8;
    localparam int EV_W     = 3;
    localparam int VAD_W    = 16;
    localparam int HANG_W   = 16;
    localparam int LEN_W    = 24;
    localparam int PEND_W   = 8;
    localparam int CFG_W    = 24;
    localparam int IDX_W    = 2;

    localparam int VSQ_W  = 2 * VAD_W;
    localparam int SQ_W   = 2 * SAMPLE_W - 1;
    localparam int SUM_W  = SQ_W + $clog2(FRAME_SAMPLES);
    localparam int THR_W  = VSQ_W + $clog2(FRAME_SAMPLES + 1);
    localparam int CMP_W  = (THR_W > SUM_W) ? THR_W : SUM_W;
    localparam int FILL_W = $clog2(FRAME_SAMPLES);
    localparam int PRE_W  = $clog2(PREROLL_FRAMES + 1);
    localparam int ONS_W  = $clog2(ONSET_FRAMES + 1);
    localparam int MARK_LEN = 7;
    localparam int POS_W  = $clog2(MARK_LEN + 1);

    localparam logic [VAD_W-1:0]  VAD_RESET  = 16'd400;
    localparam logic [HANG_W-1:0] HANG_RESET = 16'd700;
    localparam logic [LEN_W-1:0]  MIN_RESET  = 24'd8000;

    localparam logic [IDX_W-1:0] REG_VAD_LEVEL = 2'd0;
    localparam logic [IDX_W-1:0] REG_HANG_MS   = 2'd1;
    localparam logic [IDX_W-1:0] REG_MIN_TURN  = 2'd2;

    localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REPLY  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_END    = 2'd2;

    localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
    localparam logic [EV_W-1:0] EV_START   = 3'd1;
    localparam logic [EV_W-1:0] EV_BARGE   = 3'd2;
    localparam logic [EV_W-1:0] EV_CLOSED  = 3'd3;
    localparam logic [EV_W-1:0] EV_DROPPED = 3'd4;

    typedef struct packed {
        logic [ACT_W-1:0]           action;
        logic signed [SAMPLE_W-1:0] sample;
        logic [BYTE_W-1:0]          reply_byte;
    } t_in_item;

    typedef struct packed {
        logic [EV_W-1:0]   event_res;
        logic              voiced;
        logic              in_utterance;
        logic [LEN_W-1:0]  utterance_samples;
        logic              interrupted;
        logic [PEND_W-1:0] pending_replies;
    } t_out_item;

    typedef struct packed {
        logic frame_end;
        logic voiced;
    } t_frame;

    // Bytes of the end-of-reply marker "<turn|>".
    function automatic logic [BYTE_W-1:0] mark_byte(input logic [POS_W-1:0] pos);
        logic [BYTE_W-1:0] b;
        case (pos)
            3'd0: b = 8'h3C;
            3'd1: b = 8'h74;
            3'd2: b = 8'h75;
            3'd3: b = 8'h72;
            3'd4: b = 8'h6E;
            3'd5: b = 8'h7C;
            3'd6: b = 8'h3E;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: sv/evt_frame.sv
`timescale 1ns / 1ps
// Frame energy accumulator and voicing decision.
module evt_frame (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_go,
    input  logic [evt_pkg::ACT_W-1:0]  i_action,
    input  logic [evt_pkg::SQ_W-1:0]   i_sq,
    input  logic [evt_pkg::THR_W-1:0]  i_thr,
    output evt_pkg::t_frame            o_frame
);

    logic [evt_pkg::SUM_W-1:0]  r_sum;
    logic [evt_pkg::FILL_W-1:0] r_fill;
    logic [evt_pkg::SUM_W-1:0]  n_sum;
    logic [evt_pkg::FILL_W-1:0] n_fill;
    logic [evt_pkg::SUM_W-1:0]  acc;
    logic                       last;

    always_comb begin
        acc  = r_sum + evt_pkg::SUM_W'(i_sq);
        last = (i_action == evt_pkg::ACT_SAMPLE)
            && (r_fill == evt_pkg::FILL_W'(evt_pkg::FRAME_SAMPLES - 1));
        o_frame.frame_end = last;
        o_frame.voiced    = evt_pkg::CMP_W'(acc) >= evt_pkg::CMP_W'(i_thr);
        n_sum  = r_sum;
        n_fill = r_fill;
        case (i_action)
            evt_pkg::ACT_SAMPLE: begin
                if (last) begin
                    n_sum  = '0;
                    n_fill = '0;
                end else begin
                    n_sum  = acc;
                    n_fill = r_fill + 1'b1;
                end
            end
            // End of source throws the partial frame away.
            evt_pkg::ACT_END: begin
                n_sum  = '0;
                n_fill = '0;
            end
            default: begin
                n_sum  = r_sum;
                n_fill = r_fill;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_fill <= '0;
        end else if (i_go) begin
            r_sum  <= n_sum;
            r_fill <= n_fill;
        end
    end

endmodule

// File: sv/evt_ctrl.sv
`timescale 1ns / 1ps
// Utterance tracking, turn bookkeeping and reply marker matching.
module evt_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  logic [evt_pkg::ACT_W-1:0]   i_action,
    input  logic [evt_pkg::BYTE_W-1:0]  i_reply_byte,
    input  evt_pkg::t_frame             i_frame,
    input  logic [evt_pkg::HANG_W-1:0]  i_hang,
    input  logic [evt_pkg::LEN_W-1:0]   i_min_turn,
    output logic                        o_res_valid,
    output evt_pkg::t_out_item          o_res
);

    logic [evt_pkg::ONS_W-1:0]  r_onset,   n_onset;
    logic                       r_active,  n_active;
    logic [evt_pkg::HANG_W-1:0] r_silence, n_silence;
    logic [evt_pkg::PRE_W-1:0]  r_preroll, n_preroll;
    logic [evt_pkg::LEN_W-1:0]  r_len,     n_len;
    logic [evt_pkg::PEND_W-1:0] r_pending, n_pending;
    logic                       r_armed,   n_armed;
    logic                       r_barge,   n_barge;
    logic [evt_pkg::POS_W-1:0]  r_pos,     n_pos;

    logic [evt_pkg::EV_W-1:0]   ev;
    logic                       vo;
    logic                       intr;
    logic                       close;
    logic                       hit;
    logic [evt_pkg::POS_W-1:0]  pos;
    logic [evt_pkg::LEN_W:0]    len_sum;
    logic [evt_pkg::HANG_W:0]   sil_sum;

    always_comb begin
        n_onset   = r_onset;
        n_active  = r_active;
        n_silence = r_silence;
        n_preroll = r_preroll;
        n_len     = r_len;
        n_pending = r_pending;
        n_armed   = r_armed;
        n_barge   = r_barge;
        n_pos     = r_pos;
        ev          = evt_pkg::EV_NONE;
        vo          = 1'b0;
        intr        = 1'b0;
        close       = 1'b0;
        hit         = 1'b0;
        o_res_valid = 1'b0;
        pos     = (r_pos < evt_pkg::POS_W'(evt_pkg::MARK_LEN)) ? r_pos : '0;
        len_sum = {1'b0, r_len} + (evt_pkg::LEN_W + 1)'(evt_pkg::FRAME_SAMPLES);
        sil_sum = {1'b0, r_silence} + (evt_pkg::HANG_W + 1)'(evt_pkg::FRAME_MS);

        case (i_action)
            evt_pkg::ACT_SAMPLE: begin
                if (i_frame.frame_end) begin
                    o_res_valid = 1'b1;
                    vo = i_frame.voiced;
                    if (!r_active) begin
                        if (r_preroll < evt_pkg::PRE_W'(evt_pkg::PREROLL_FRAMES)) begin
                            n_preroll = r_preroll + 1'b1;
                        end
                        if (!vo) begin
                            n_onset = '0;
                        end else if (r_onset < evt_pkg::ONS_W'(evt_pkg::ONSET_FRAMES)) begin
                            n_onset = r_onset + 1'b1;
                        end
                        if (n_onset >= evt_pkg::ONS_W'(evt_pkg::ONSET_FRAMES)) begin
                            ev = evt_pkg::EV_START;
                            if ((r_pending != '0) && r_armed) begin
                                ev      = evt_pkg::EV_BARGE;
                                n_barge = 1'b1;
                                n_armed = 1'b0;
                            end
                            // Preroll times frame length stays far below the length limit.
                            n_len = evt_pkg::LEN_W'(n_preroll)
                                * evt_pkg::LEN_W'(evt_pkg::FRAME_SAMPLES);
                            n_active  = 1'b1;
                            n_silence = '0;
                            n_onset   = '0;
                        end
                    end else begin
                        n_len = len_sum[evt_pkg::LEN_W] ? '1 : len_sum[evt_pkg::LEN_W-1:0];
                        if (vo) begin
                            n_silence = '0;
                        end else begin
                            n_silence = sil_sum[evt_pkg::HANG_W]
                                ? '1 : sil_sum[evt_pkg::HANG_W-1:0];
                        end
                    end
                    close = n_active && (n_silence >= i_hang);
                end
            end
            evt_pkg::ACT_REPLY: begin
                if (i_reply_byte == evt_pkg::mark_byte(pos)) begin
                    if (pos == evt_pkg::POS_W'(evt_pkg::MARK_LEN - 1)) begin
                        hit   = 1'b1;
                        n_pos = '0;
                    end else begin
                        n_pos = pos + 1'b1;
                    end
                end else begin
                    n_pos = (i_reply_byte == evt_pkg::mark_byte('0)) ? 3'd1 : 3'd0;
                end
                if (hit) begin
                    o_res_valid = 1'b1;
                    if (r_pending != '0) begin
                        n_pending = r_pending - 1'b1;
                    end
                end
            end
            evt_pkg::ACT_END: begin
                o_res_valid = 1'b1;
                n_onset     = '0;
                close       = r_active;
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase

        if (close) begin
            n_active  = 1'b0;
            n_silence = '0;
            if (n_len >= i_min_turn) begin
                ev      = evt_pkg::EV_CLOSED;
                intr    = n_barge;
                n_barge = 1'b0;
                n_armed = 1'b1;
                if (n_pending != '1) begin
                    n_pending = n_pending + 1'b1;
                end
            end else begin
                // A dropped utterance leaves the barge state for the next turn.
                ev = evt_pkg::EV_DROPPED;
            end
        end

        o_res.event_res         = ev;
        o_res.voiced            = vo;
        o_res.in_utterance      = n_active;
        o_res.utterance_samples = n_len;
        o_res.interrupted       = intr;
        o_res.pending_replies   = n_pending;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_onset   <= '0;
            r_active  <= 1'b0;
            r_silence <= '0;
            r_preroll <= '0;
            r_len     <= '0;
            r_pending <= '0;
            r_armed   <= 1'b1;
            r_barge   <= 1'b0;
            r_pos     <= '0;
        end else if (i_go) begin
            r_onset   <= n_onset;
            r_active  <= n_active;
            r_silence <= n_silence;
            r_preroll <= n_preroll;
            r_len     <= n_len;
            r_pending <= n_pending;
            r_armed   <= n_armed;
            r_barge   <= n_barge;
            r_pos     <= n_pos;
        end
    end

    a_start_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && ((o_res.event_res == evt_pkg::EV_START)
            || (o_res.event_res == evt_pkg::EV_BARGE))) |-> o_res.in_utterance)
        else $error("start event reported without an open utterance");

    a_close_shuts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && ((o_res.event_res == evt_pkg::EV_CLOSED)
            || (o_res.event_res == evt_pkg::EV_DROPPED))) |-> !o_res.in_utterance)
        else $error("close event reported with the utterance still open");

    a_intr_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.interrupted) |-> (o_res.event_res == evt_pkg::EV_CLOSED))
        else $error("interrupted flag outside a closed turn");

    a_barge_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && o_res_valid && (o_res.event_res == evt_pkg::EV_BARGE)) |=> !r_armed)
        else $error("barge did not disarm");

endmodule

// File: sv/energy_vad_turn_taker.sv
`timescale 1ns / 1ps
// Top level of the energy voice activity detector and turn taker.
// The block takes one request per clock cycle unless a stalled result holds it: a mic sample,
// a reply byte or an end-of-source mark. A request waits in the input register (its sample
// already squared) until it advances, and its result, if any, is then registered into the
// output register; the sustained rate is one request per cycle without result stalls, set
// by the single accumulate and compare per sample. Results come at each completed 320-sample
// frame, at each end of source and at each complete "<turn|>" marker in the reply bytes.
// While a result waits under a stall nothing advances: the input register keeps its request
// and the input stalls once that register is full. A write to vad_level reaches the frame
// threshold via the squared-level and threshold registers; writes are expected only when idle.
module energy_vad_turn_taker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  evt_pkg::t_in_item           i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output evt_pkg::t_out_item          o_out_item,
    input  logic                        i_cfg_we,
    input  logic [evt_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [evt_pkg::CFG_W-1:0]   i_cfg_data
);

    logic                          r_in_valid;
    evt_pkg::t_in_item             r_in;
    logic [evt_pkg::SQ_W-1:0]      r_sq;
    logic                          r_out_valid;
    evt_pkg::t_out_item            r_out;
    logic [evt_pkg::VSQ_W-1:0]     r_vad_sq;
    logic [evt_pkg::THR_W-1:0]     r_thr;
    logic [evt_pkg::HANG_W-1:0]    r_hang;
    logic [evt_pkg::LEN_W-1:0]     r_min_turn;

    logic                          adv;
    logic                          go;
    logic                          accept;
    logic [evt_pkg::SAMPLE_W-1:0]  mag;
    logic [evt_pkg::VAD_W-1:0]     cfg_vad;
    evt_pkg::t_frame               frame;
    logic                          res_valid;
    evt_pkg::t_out_item            res;

    assign adv        = !r_out_valid || !i_out_stall;
    assign go         = r_in_valid && adv;
    assign o_in_stall = r_in_valid && !adv;
    assign accept     = i_in_valid && !o_in_stall;
    assign cfg_vad    = i_cfg_data[evt_pkg::VAD_W-1:0];
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Magnitude as unsigned, so the most negative sample squares correctly.
    assign mag = i_in_item.sample[evt_pkg::SAMPLE_W-1]
        ? (~i_in_item.sample + 1'b1) : i_in_item.sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_vad_sq    <= evt_pkg::VSQ_W'(evt_pkg::VAD_RESET) * evt_pkg::VSQ_W'(evt_pkg::VAD_RESET);
            r_thr       <= evt_pkg::THR_W'(evt_pkg::VSQ_W'(evt_pkg::VAD_RESET)
                * evt_pkg::VSQ_W'(evt_pkg::VAD_RESET)) * evt_pkg::THR_W'(evt_pkg::FRAME_SAMPLES);
            r_hang      <= evt_pkg::HANG_RESET;
            r_min_turn  <= evt_pkg::MIN_RESET;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= go && res_valid;
            end
            r_thr <= evt_pkg::THR_W'(r_vad_sq) * evt_pkg::THR_W'(evt_pkg::FRAME_SAMPLES);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    evt_pkg::REG_VAD_LEVEL: begin
                        r_vad_sq <= evt_pkg::VSQ_W'(cfg_vad) * evt_pkg::VSQ_W'(cfg_vad);
                    end
                    evt_pkg::REG_HANG_MS: begin
                        r_hang <= i_cfg_data[evt_pkg::HANG_W-1:0];
                    end
                    evt_pkg::REG_MIN_TURN: begin
                        r_min_turn <= i_cfg_data[evt_pkg::LEN_W-1:0];
                    end
                    default: begin
                        r_hang <= r_hang;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_item;
            r_sq <= evt_pkg::SQ_W'((2 * evt_pkg::SAMPLE_W)'(mag) * (2 * evt_pkg::SAMPLE_W)'(mag));
        end
        if (go && res_valid) begin
            r_out <= res;
        end
    end

    evt_frame u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_action (r_in.action),
        .i_sq     (r_sq),
        .i_thr    (r_thr),
        .o_frame  (frame)
    );

    evt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (go),
        .i_action     (r_in.action),
        .i_reply_byte (r_in.reply_byte),
        .i_frame      (frame),
        .i_hang       (r_hang),
        .i_min_turn   (r_min_turn),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && o_in_stall) |=> r_in_valid)
        else $error("request in the input register lost while stalled");

    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !go)
        else $error("stage advanced into a stalled result");

    a_result_from_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_out_valid) && r_out_valid) |-> $past(go && res_valid))
        else $error("result appeared without a processed request");

endmodule

// File: sim/tb_energy_vad_turn_taker.sv
`timescale 1ns / 1ps
// Self-checking testbench of the energy voice activity detector and turn taker.
import evt_pkg::*;

localparam logic [ACT_W-1:0] ACT_RESERVED = 2'd3;
localparam logic [8*MARK_LEN-1:0] TURN_MARK = "<turn|>";

function automatic logic [BYTE_W-1:0] mark_char(input int unsigned pos);
    return TURN_MARK[8*(MARK_LEN-1-pos) +: 8];
endfunction

class turn_scoreboard;
    logic [VAD_W-1:0]  vad_level;
    logic [HANG_W-1:0] hang_ms;
    logic [LEN_W-1:0]  min_turn;
    logic [SUM_W-1:0]  energy;
    int unsigned       fill;
    logic [ONS_W-1:0]  onset;
    logic              talking;
    logic [HANG_W-1:0] silence;
    logic [PRE_W-1:0]  preroll;
    logic [LEN_W-1:0]  length;
    logic [PEND_W-1:0] pending;
    logic              barge_ready;
    logic              barged;
    int unsigned       match_pos;
    t_out_item         expected_q[$];
    int unsigned       errors;

    function new();
        vad_level   = VAD_RESET;
        hang_ms     = HANG_RESET;
        min_turn    = MIN_RESET;
        energy      = '0;
        fill        = 0;
        onset       = '0;
        talking     = 1'b0;
        silence     = '0;
        preroll     = '0;
        length      = '0;
        pending     = '0;
        barge_ready = 1'b1;
        barged      = 1'b0;
        match_pos   = 0;
        errors      = 0;
    endfunction

    function void set_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        case (idx)
            REG_VAD_LEVEL: vad_level = data[VAD_W-1:0];
            REG_HANG_MS:   hang_ms = data[HANG_W-1:0];
            REG_MIN_TURN:  min_turn = data[LEN_W-1:0];
            default: ;
        endcase
    endfunction

    function void record(input logic [EV_W-1:0] ev, input logic vo, input logic intr);
        t_out_item res;
        res.event_res         = ev;
        res.voiced            = vo;
        res.in_utterance      = talking;
        res.utterance_samples = length;
        res.interrupted       = intr;
        res.pending_replies   = pending;
        expected_q.push_back(res);
    endfunction

    // Short utterances are dropped and leave the barge state alone.
    function logic [EV_W-1:0] close_utterance(output logic intr);
        talking = 1'b0;
        silence = '0;
        intr = 1'b0;
        if (length < min_turn) return EV_DROPPED;
        intr = barged;
        barged = 1'b0;
        barge_ready = 1'b1;
        if (pending != '1) pending++;
        return EV_CLOSED;
    endfunction

    function void note_request(input t_in_item req);
        logic [SAMPLE_W-1:0] raw;
        int unsigned         mag;
        int unsigned         pos;
        logic [CMP_W-1:0]    thr;
        logic [LEN_W:0]      grown;
        logic [HANG_W:0]     quiet_ms;
        logic [EV_W-1:0]     ev;
        logic                vo;
        logic                intr;
        ev = EV_NONE;
        vo = 1'b0;
        intr = 1'b0;
        case (req.action)
            ACT_SAMPLE: begin
                raw = req.sample;
                mag = raw[SAMPLE_W-1] ? 32'h10000 - raw : raw;
                energy = energy + SUM_W'(mag * mag);
                fill++;
                if (fill < FRAME_SAMPLES) return;
                thr = CMP_W'(vad_level) * CMP_W'(vad_level) * CMP_W'(FRAME_SAMPLES);
                vo = CMP_W'(energy) >= thr;
                energy = '0;
                fill = 0;
                if (!talking) begin
                    if (preroll < PREROLL_FRAMES) preroll++;
                    if (vo) begin
                        if (onset < ONSET_FRAMES) onset++;
                    end else begin
                        onset = '0;
                    end
                    if (onset >= ONSET_FRAMES) begin
                        ev = EV_START;
                        if (pending != 0 && barge_ready) begin
                            ev = EV_BARGE;
                            barged = 1'b1;
                            barge_ready = 1'b0;
                        end
                        length = LEN_W'(preroll * FRAME_SAMPLES);
                        talking = 1'b1;
                        silence = '0;
                        onset = '0;
                    end
                end else begin
                    grown = {1'b0, length} + (LEN_W+1)'(FRAME_SAMPLES);
                    length = grown[LEN_W] ? '1 : grown[LEN_W-1:0];
                    if (vo) begin
                        silence = '0;
                    end else begin
                        quiet_ms = {1'b0, silence} + (HANG_W+1)'(FRAME_MS);
                        silence = quiet_ms[HANG_W] ? '1 : quiet_ms[HANG_W-1:0];
                    end
                end
                // With a zero hang time the frame that opens an utterance also closes it.
                if (talking && silence >= hang_ms) ev = close_utterance(intr);
                record(ev, vo, intr);
            end
            ACT_REPLY: begin
                pos = match_pos < MARK_LEN ? match_pos : 0;
                if (req.reply_byte == mark_char(pos)) begin
                    pos++;
                end else begin
                    pos = (req.reply_byte == mark_char(0)) ? 1 : 0;
                end
                if (pos >= MARK_LEN) begin
                    match_pos = 0;
                    if (pending != 0) pending--;
                    record(EV_NONE, 1'b0, 1'b0);
                end else begin
                    match_pos = pos;
                end
            end
            ACT_END: begin
                energy = '0;
                fill = 0;
                onset = '0;
                if (talking) ev = close_utterance(intr);
                record(ev, 1'b0, intr);
            end
            default: ;
        endcase
    endfunction

    function void check_result(input t_out_item got);
        t_out_item want;
        if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: result with none expected: ev=%0d v=%0b u=%0b len=%0d int=%0b pend=%0d",
                     $time, got.event_res, got.voiced, got.in_utterance,
                     got.utterance_samples, got.interrupted, got.pending_replies);
            return;
        end
        want = expected_q.pop_front();
        if (got.event_res !== want.event_res || got.voiced !== want.voiced ||
            got.in_utterance !== want.in_utterance ||
            got.utterance_samples !== want.utterance_samples ||
            got.interrupted !== want.interrupted ||
            got.pending_replies !== want.pending_replies) begin
            errors++;
            $display({"%0t: mismatch: expected ev=%0d v=%0b u=%0b len=%0d int=%0b pend=%0d,",
                      " got ev=%0d v=%0b u=%0b len=%0d int=%0b pend=%0d"}, $time,
                     want.event_res, want.voiced, want.in_utterance,
                     want.utterance_samples, want.interrupted, want.pending_replies,
                     got.event_res, got.voiced, got.in_utterance,
                     got.utterance_samples, got.interrupted, got.pending_replies);
        end
    endfunction
endclass

module tb_energy_vad_turn_taker;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum int {FR_LOUD, FR_QUIET, FR_WILD} frame_kind_e;

    logic              i_clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    t_in_item          in_item = '0;
    logic              out_stall = 1'b0;
    logic              cfg_we = 1'b0;
    logic [IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              o_in_stall;
    logic              o_out_valid;
    t_out_item         o_out_item;

    logic              tx_idle_on = 1'b1;
    logic              rx_idle_on = 1'b1;
    logic              hold_req = 1'b0;
    logic              hold_seen = 1'b0;
    int unsigned       quiet_cycles = 0;
    turn_scoreboard    sb = new();

    energy_vad_turn_taker u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        logic moved;
        moved = 1'b0;
        if (in_valid && !o_in_stall) begin
            sb.note_request(in_item);
            moved = 1'b1;
        end
        if (rst_n && o_out_valid && !out_stall) begin
            sb.check_result(o_out_item);
            moved = 1'b1;
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on demand.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            out_stall <= rx_idle_on && ($urandom_range(99, 0) < 6);
        end
    end

    // Returns at the rising edge that accepts the request.
    task automatic send_req(input logic [ACT_W-1:0] act, input logic [SAMPLE_W-1:0] smp,
                            input logic [BYTE_W-1:0] rb);
        t_in_item req;
        req.action = act;
        req.sample = smp;
        req.reply_byte = rb;
        @(negedge i_clk);
        while (tx_idle_on && $urandom_range(99, 0) < 6) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        send_req(ACT_SAMPLE, smp, BYTE_W'($urandom));
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] rb);
        send_req(ACT_REPLY, SAMPLE_W'($urandom), rb);
    endtask

    task automatic send_end();
        send_req(ACT_END, SAMPLE_W'($urandom), BYTE_W'($urandom));
    endtask

    task automatic send_marker();
        for (int k = 0; k < MARK_LEN; k++) send_byte(mark_char(k));
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input int unsigned lo,
                                                        input int unsigned hi);
        int unsigned mag;
        mag = $urandom_range(hi, lo);
        if (mag > 32767 || (mag != 0 && $urandom_range(1, 0) == 1))
            return SAMPLE_W'(32'h10000 - mag);
        return SAMPLE_W'(mag);
    endfunction

    task automatic play_frame(input frame_kind_e kind);
        int unsigned lvl;
        int unsigned top;
        logic [SAMPLE_W-1:0] smp;
        lvl = sb.vad_level;
        top = (lvl + 1500 > 32768) ? 32768 : lvl + 1500;
        for (int i = 0; i < FRAME_SAMPLES; i++) begin
            case (kind)
                FR_LOUD:  smp = pick_sample(lvl, top);
                FR_QUIET: smp = pick_sample(0, lvl == 0 ? 0 : lvl - 1);
                default:  smp = SAMPLE_W'($urandom);
            endcase
            send_sample(smp);
        end
    endtask

    // Every sample sits exactly at the threshold level; one short sample tips it to silence.
    task automatic send_level_frame(input bit one_short);
        int unsigned lvl;
        int unsigned short_at;
        int unsigned mag;
        lvl = sb.vad_level;
        short_at = one_short ? $urandom_range(FRAME_SAMPLES - 1, 0) : FRAME_SAMPLES;
        for (int i = 0; i < FRAME_SAMPLES; i++) begin
            mag = (i == short_at && lvl != 0) ? lvl - 1 : lvl;
            send_sample(pick_sample(mag, mag));
        end
    endtask

    task automatic run_chatter();
        repeat ($urandom_range(6, 3)) begin
            case ($urandom_range(9, 0))
                0, 1, 2: send_marker();
                3: begin
                    for (int k = 0; k < $urandom_range(MARK_LEN - 1, 1); k++)
                        send_byte(mark_char(k));
                    send_byte(BYTE_W'($urandom));
                end
                4, 5: send_byte(BYTE_W'($urandom));
                6: send_req(ACT_RESERVED, SAMPLE_W'($urandom), BYTE_W'($urandom));
                7: send_end();
                default: repeat ($urandom_range(20, 1)) send_sample(SAMPLE_W'($urandom));
            endcase
        end
    endtask

    // Waits until every expected result is in and the pipeline has drained.
    task automatic settle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    task automatic configure(input int unsigned vad, input int unsigned hang,
                             input int unsigned min_len);
        settle();
        write_reg(REG_VAD_LEVEL, CFG_W'(vad));
        write_reg(REG_HANG_MS, CFG_W'(hang));
        write_reg(REG_MIN_TURN, CFG_W'(min_len));
        repeat (2) @(negedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // Reset settings: odd actions, marker handling with nothing pending, sample extremes.
        send_req(ACT_RESERVED, SAMPLE_W'($urandom), BYTE_W'($urandom));
        send_end();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_marker();
        send_byte(mark_char(0));
        send_byte(mark_char(1));
        send_marker();
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        send_end();

        // The receiver holds off while requests keep coming, so the block fills and stalls.
        hold_req <= ~hold_req;
        repeat (8) begin
            if ($urandom_range(1, 0)) send_end();
            else send_marker();
        end

        // Three voiced frames open an utterance; the first one sits exactly on the threshold.
        send_level_frame(1'b0);
        repeat (ONSET_FRAMES - 1) play_frame(FR_LOUD);

        // End of source closes it as a turn, which leaves one reply pending.
        configure(sb.vad_level, sb.hang_ms, $urandom_range(ONSET_FRAMES * FRAME_SAMPLES, 0));
        repeat ($urandom_range(20, 1)) send_sample(SAMPLE_W'($urandom));
        send_end();

        // The next utterance opens while a reply is pending. No idling on either side here.
        configure($urandom_range(3000, 20), FRAME_MS * $urandom_range(1, 0),
                  $urandom_range(3000, 0));
        tx_idle_on <= 1'b0;
        rx_idle_on <= 1'b0;
        repeat (ONSET_FRAMES) play_frame(FR_LOUD);
        tx_idle_on <= 1'b1;
        rx_idle_on <= 1'b1;
        repeat ($urandom_range(20, 1)) send_sample(SAMPLE_W'($urandom));
        send_end();

        // Retire whatever is left and keep going below zero.
        repeat (3) send_marker();
        run_chatter();

        settle();
        repeat (10) @(negedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: energy_vad_turn_taker.f
sv/evt_pkg.sv
sv/evt_frame.sv
sv/evt_ctrl.sv
sv/energy_vad_turn_taker.sv
sim/tb_energy_vad_turn_taker.sv
